>>> src/sha1md_pkg.sv
`default_nettype none

package sha1md_pkg;

  localparam int unsigned BLOCK_WORDS = 16;
  localparam int unsigned ROUNDS      = 80;
  localparam int unsigned RND_W       = $clog2(ROUNDS);
  localparam int unsigned POS_W       = $clog2(BLOCK_WORDS);
  localparam int unsigned DIGEST_WORDS = 5;

  localparam logic [31:0] H_INIT [DIGEST_WORDS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [31:0] K_R0 = 32'h5A827999;
  localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_R3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN_LO,
    ST_ROUND,
    ST_ADD
  } state_t;

  typedef enum logic [1:0] {
    RET_IDLE,
    RET_PAD,
    RET_DONE
  } ret_t;

  typedef enum logic [2:0] {
    SEL_MSG,
    SEL_EXTRA,
    SEL_ZERO,
    SEL_LEN_HI,
    SEL_LEN_LO
  } push_sel_t;

  typedef struct packed {
    logic      push;
    push_sel_t sel;
    logic      start;
    logic      round;
    logic      add;
    logic      done;
  } cmd_t;

  typedef struct packed {
    logic pos_last;
    logic pos_len;
    logic round_last;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

>>> src/sha1md_in_if.sv
`default_nettype none

interface sha1md_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] message_word;
  logic [2:0]  byte_count;
  logic        end_of_message;

  modport source (
    output valid, message_word, byte_count, end_of_message,
    input  ready
  );
  modport sink (
    input  valid, message_word, byte_count, end_of_message,
    output ready
  );
endinterface

`default_nettype wire

>>> src/sha1md_out_if.sv
`default_nettype none

interface sha1md_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (
    output valid, digest_word, word_index, last_word,
    input  ready
  );
  modport sink (
    input  valid, digest_word, word_index, last_word,
    output ready
  );
endinterface

`default_nettype wire

>>> src/sha1_message_digest.sv
// SHA-1 digest engine. Message bytes arrive one 32-bit word per input beat, first byte in
// bits 31:24; non-final words always carry four bytes, and the final word's byte_count (0-4;
// larger values act as 4) selects its valid top bytes. Words are taken one per cycle while
// the block is idle; every sixteenth word starts the compression, which holds off input
// through 80 rounds at one round per clock in a single shared round unit and then the
// chaining add. After the final word the block appends padding and the 64-bit length at one
// word per cycle between compressions, runs one or two more compressions, and then presents
// the five digest words as output beats, index 0 first, last_word set on index 4. The digest
// sits in its own output register, so the next message may start while the digest is still
// being taken; a second digest waits only if the first has not fully drained.
`default_nettype none

module sha1_message_digest (
  input  wire logic    clk,
  input  wire logic    rst_n,
  sha1md_in_if.sink    in_if,
  sha1md_out_if.source out_if
);

  sha1md_pkg::cmd_t cmd;
  sha1md_pkg::sts_t sts;

  sha1md_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_last  (in_if.end_of_message),
    .in_full  (in_if.byte_count[2]),
    .in_ready (in_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sha1md_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_word   (in_if.message_word),
    .in_count  (in_if.byte_count),
    .in_last   (in_if.end_of_message),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_word  (out_if.digest_word),
    .out_index (out_if.word_index),
    .out_last  (out_if.last_word)
  );

endmodule

`default_nettype wire

>>> src/sha1md_datapath.sv
`default_nettype none

module sha1md_datapath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire sha1md_pkg::cmd_t  cmd,
  output sha1md_pkg::sts_t       sts,
  input  wire logic [31:0]       in_word,
  input  wire logic [2:0]        in_count,
  input  wire logic              in_last,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [31:0]            out_word,
  output logic [2:0]             out_index,
  output logic                   out_last
);

  localparam int unsigned NW = sha1md_pkg::BLOCK_WORDS;
  localparam int unsigned ND = sha1md_pkg::DIGEST_WORDS;

  logic [31:0] h_r   [ND];
  logic [31:0] v_r   [ND];
  logic [31:0] w_r   [NW];
  logic [31:0] dig_r [ND];
  logic [sha1md_pkg::POS_W-1:0] pos_r;
  logic [sha1md_pkg::RND_W-1:0] rnd_r;
  logic [63:0] len_r;
  logic [2:0]  oidx_r;
  logic        busy_r;

  logic [31:0] keep;
  logic [31:0] pad_w;
  logic [5:0]  len_add;
  logic [31:0] msg_word;
  logic [31:0] push_word;
  logic [31:0] f_val;
  logic [31:0] k_val;
  logic [31:0] sum;
  logic [31:0] w_mix;
  logic [31:0] w_new;
  logic [31:0] h_sum [ND];

  always_comb begin
    unique case (in_count)
      3'd0: begin
        keep = 32'h0000_0000; pad_w = {sha1md_pkg::PAD_BYTE, 24'h0};         len_add = 6'd0;
      end
      3'd1: begin
        keep = 32'hFF00_0000; pad_w = {8'h0, sha1md_pkg::PAD_BYTE, 16'h0};   len_add = 6'd8;
      end
      3'd2: begin
        keep = 32'hFFFF_0000; pad_w = {16'h0, sha1md_pkg::PAD_BYTE, 8'h0};   len_add = 6'd16;
      end
      3'd3: begin
        keep = 32'hFFFF_FF00; pad_w = {24'h0, sha1md_pkg::PAD_BYTE};         len_add = 6'd24;
      end
      default: begin
        keep = 32'hFFFF_FFFF; pad_w = 32'h0;                                 len_add = 6'd32;
      end
    endcase
  end

  assign msg_word = in_last ? ((in_word & keep) | pad_w) : in_word;

  always_comb begin
    unique case (cmd.sel)
      sha1md_pkg::SEL_MSG:    push_word = msg_word;
      sha1md_pkg::SEL_EXTRA:  push_word = {sha1md_pkg::PAD_BYTE, 24'h0};
      sha1md_pkg::SEL_ZERO:   push_word = 32'h0;
      sha1md_pkg::SEL_LEN_HI: push_word = len_r[63:32];
      sha1md_pkg::SEL_LEN_LO: push_word = len_r[31:0];
      default:                push_word = 32'h0;
    endcase
  end

  always_comb begin
    priority if (rnd_r < sha1md_pkg::RND_W'(20)) begin
      f_val = v_r[3] ^ (v_r[1] & (v_r[2] ^ v_r[3]));
      k_val = sha1md_pkg::K_R0;
    end else if (rnd_r < sha1md_pkg::RND_W'(40)) begin
      f_val = v_r[1] ^ v_r[2] ^ v_r[3];
      k_val = sha1md_pkg::K_R1;
    end else if (rnd_r < sha1md_pkg::RND_W'(60)) begin
      f_val = (v_r[1] & v_r[2]) | (v_r[3] & (v_r[1] | v_r[2]));
      k_val = sha1md_pkg::K_R2;
    end else begin
      f_val = v_r[1] ^ v_r[2] ^ v_r[3];
      k_val = sha1md_pkg::K_R3;
    end
  end

  assign sum   = {v_r[0][26:0], v_r[0][31:27]} + f_val + v_r[4] + k_val + w_r[0];
  assign w_mix = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
  assign w_new = {w_mix[30:0], w_mix[31]};

  always_comb begin
    for (int i = 0; i < ND; i++) begin
      h_sum[i] = h_r[i] + v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      for (int i = 0; i < NW - 1; i++) w_r[i] <= w_r[i+1];
      w_r[NW-1] <= push_word;
    end else if (cmd.round) begin
      for (int i = 0; i < NW - 1; i++) w_r[i] <= w_r[i+1];
      w_r[NW-1] <= w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      for (int i = 0; i < ND; i++) v_r[i] <= h_r[i];
    end else if (cmd.round) begin
      v_r[0] <= sum;
      v_r[1] <= v_r[0];
      v_r[2] <= {v_r[1][1:0], v_r[1][31:2]};
      v_r[3] <= v_r[2];
      v_r[4] <= v_r[3];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ND; i++) h_r[i] <= sha1md_pkg::H_INIT[i];
      pos_r <= '0;
      len_r <= '0;
      rnd_r <= '0;
    end else begin
      if (cmd.add) begin
        for (int i = 0; i < ND; i++) begin
          h_r[i] <= cmd.done ? sha1md_pkg::H_INIT[i] : h_sum[i];
        end
      end
      if (cmd.push) begin
        pos_r <= pos_r + 1'b1;
        if (cmd.sel == sha1md_pkg::SEL_MSG) begin
          len_r <= len_r + {58'h0, in_last ? len_add : 6'd32};
        end else if (cmd.sel == sha1md_pkg::SEL_LEN_LO) begin
          len_r <= '0;
        end
      end
      if (cmd.start) begin
        rnd_r <= '0;
      end else if (cmd.round) begin
        rnd_r <= rnd_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.done) begin
      for (int i = 0; i < ND; i++) dig_r[i] <= h_sum[i];
    end else if (busy_r && out_ready) begin
      for (int i = 0; i < ND - 1; i++) dig_r[i] <= dig_r[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      oidx_r <= '0;
    end else if (cmd.done) begin
      busy_r <= 1'b1;
      oidx_r <= '0;
    end else if (busy_r && out_ready) begin
      oidx_r <= oidx_r + 1'b1;
      if (oidx_r == 3'(ND - 1)) busy_r <= 1'b0;
    end
  end

  assign sts.pos_last   = (pos_r == sha1md_pkg::POS_W'(NW - 1));
  assign sts.pos_len    = (pos_r == sha1md_pkg::POS_W'(NW - 2));
  assign sts.round_last = (rnd_r == sha1md_pkg::RND_W'(sha1md_pkg::ROUNDS - 1));
  assign sts.out_busy   = busy_r;

  assign out_valid = busy_r;
  assign out_word  = dig_r[0];
  assign out_index = oidx_r;
  assign out_last  = (oidx_r == 3'(ND - 1));

  a_done_idle_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.done |-> !busy_r)
    else $error("digest loaded while previous digest still draining");

  a_done_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.done |-> (pos_r == '0) && (len_r == '0))
    else $error("message finished off a block boundary");

  a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.round |-> (rnd_r < sha1md_pkg::RND_W'(sha1md_pkg::ROUNDS)))
    else $error("round counter ran past the last round");

endmodule

`default_nettype wire

>>> src/sha1md_ctrl.sv
`default_nettype none

module sha1md_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_last,
  input  wire logic              in_full,
  output logic                   in_ready,
  input  wire sha1md_pkg::sts_t  sts,
  output sha1md_pkg::cmd_t       cmd
);

  sha1md_pkg::state_t state_r, state_nxt;
  sha1md_pkg::ret_t   ret_r, ret_nxt;
  logic               pend80_r, pend80_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= sha1md_pkg::ST_IDLE;
      ret_r    <= sha1md_pkg::RET_IDLE;
      pend80_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ret_r    <= ret_nxt;
      pend80_r <= pend80_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    ret_nxt    = ret_r;
    pend80_nxt = pend80_r;
    unique case (state_r)
      sha1md_pkg::ST_IDLE: begin
        if (in_valid) begin
          pend80_nxt = in_last && in_full;
          if (sts.pos_last) begin
            state_nxt = sha1md_pkg::ST_ROUND;
            ret_nxt   = in_last ? sha1md_pkg::RET_PAD : sha1md_pkg::RET_IDLE;
          end else begin
            state_nxt = in_last ? sha1md_pkg::ST_PAD : sha1md_pkg::ST_IDLE;
          end
        end
      end
      sha1md_pkg::ST_PAD: begin
        if (pend80_r) begin
          pend80_nxt = 1'b0;
          if (sts.pos_last) begin
            state_nxt = sha1md_pkg::ST_ROUND;
            ret_nxt   = sha1md_pkg::RET_PAD;
          end
        end else if (sts.pos_len) begin
          state_nxt = sha1md_pkg::ST_LEN_LO;
        end else if (sts.pos_last) begin
          state_nxt = sha1md_pkg::ST_ROUND;
          ret_nxt   = sha1md_pkg::RET_PAD;
        end
      end
      sha1md_pkg::ST_LEN_LO: begin
        state_nxt = sha1md_pkg::ST_ROUND;
        ret_nxt   = sha1md_pkg::RET_DONE;
      end
      sha1md_pkg::ST_ROUND: begin
        if (sts.round_last) state_nxt = sha1md_pkg::ST_ADD;
      end
      sha1md_pkg::ST_ADD: begin
        unique case (ret_r)
          sha1md_pkg::RET_DONE: begin
            if (!sts.out_busy) state_nxt = sha1md_pkg::ST_IDLE;
          end
          sha1md_pkg::RET_PAD:  state_nxt = sha1md_pkg::ST_PAD;
          default:              state_nxt = sha1md_pkg::ST_IDLE;
        endcase
      end
      default: state_nxt = sha1md_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.sel  = sha1md_pkg::SEL_MSG;
    in_ready = 1'b0;
    unique case (state_r)
      sha1md_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.push  = in_valid;
        cmd.start = in_valid && sts.pos_last;
      end
      sha1md_pkg::ST_PAD: begin
        cmd.push = 1'b1;
        if (pend80_r) begin
          cmd.sel   = sha1md_pkg::SEL_EXTRA;
          cmd.start = sts.pos_last;
        end else if (sts.pos_len) begin
          cmd.sel   = sha1md_pkg::SEL_LEN_HI;
        end else begin
          cmd.sel   = sha1md_pkg::SEL_ZERO;
          cmd.start = sts.pos_last;
        end
      end
      sha1md_pkg::ST_LEN_LO: begin
        cmd.push  = 1'b1;
        cmd.sel   = sha1md_pkg::SEL_LEN_LO;
        cmd.start = 1'b1;
      end
      sha1md_pkg::ST_ROUND: begin
        cmd.round = 1'b1;
      end
      sha1md_pkg::ST_ADD: begin
        if (ret_r == sha1md_pkg::RET_DONE) begin
          cmd.add  = !sts.out_busy;
          cmd.done = !sts.out_busy;
        end else begin
          cmd.add  = 1'b1;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  a_round_to_add: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sha1md_pkg::ST_ROUND) && sts.round_last |=> (state_r == sha1md_pkg::ST_ADD))
    else $error("compression did not close after the last round");

  a_len_lo_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sha1md_pkg::ST_LEN_LO) |-> sts.pos_last)
    else $error("low length word not in the last block slot");

  a_ready_clean: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !pend80_r)
    else $error("input taken with padding still pending");

endmodule

`default_nettype wire

>>> tb/tb_sha1_message_digest.sv
`timescale 1ns / 1ps

module tb_sha1_message_digest;

  localparam int STALL_LIMIT     = 10000;
  localparam int HOLD_OFF_CYCLES = 1500;
  localparam int DRAIN_CYCLES    = 200;
  localparam int TARGET_ITEMS    = 470;
  localparam int SIDE_WORD       = 0;
  localparam int SIDE_DIGEST     = 1;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  sha1md_in_if  word_ch ();
  sha1md_out_if digest_ch ();

  sha1_message_digest i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (word_ch),
    .out_if (digest_ch)
  );

  always #4 clk = ~clk;

  logic [31:0]  chain_h [sha1md_pkg::DIGEST_WORDS];
  logic [31:0]  sched_w [sha1md_pkg::BLOCK_WORDS];
  logic [3:0]   fill_pos;
  logic [63:0]  msg_bits;
  digest_beat_t digest_q [$];

  int fail_count = 0;
  int items_sent = 0;
  int idle_cycles = 0;
  int hold_off_req = 0;
  int stretch_left [2] = '{0, 0};
  bit calm_stretch [2] = '{0, 0};

  function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
    return (x << r) | (x >> (32 - r));
  endfunction

  function automatic void compress_block();
    logic [31:0] a, b, c, d, e, f, k, w, sum;
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (int t = 0; t < sha1md_pkg::ROUNDS; t++) begin
      if (t < 16) begin
        w = sched_w[t];
      end else begin
        w = rotl(sched_w[(t - 3) % 16] ^ sched_w[(t - 8) % 16] ^
                 sched_w[(t - 14) % 16] ^ sched_w[t % 16], 1);
        sched_w[t % 16] = w;
      end
      if (t < 20) begin
        f = d ^ (b & (c ^ d));
        k = sha1md_pkg::K_R0;
      end else if (t < 40) begin
        f = b ^ c ^ d;
        k = sha1md_pkg::K_R1;
      end else if (t < 60) begin
        f = (b & c) | (d & (b | c));
        k = sha1md_pkg::K_R2;
      end else begin
        f = b ^ c ^ d;
        k = sha1md_pkg::K_R3;
      end
      sum = rotl(a, 5) + f + e + k + w;
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = sum;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endfunction

  function automatic void push_sched_word(input logic [31:0] w);
    sched_w[fill_pos] = w;
    fill_pos = fill_pos + 4'd1;
    if (fill_pos == 4'd0) begin
      compress_block();
    end
  endfunction

  function automatic void clear_digest_state();
    chain_h = sha1md_pkg::H_INIT;
    fill_pos = '0;
    msg_bits = '0;
  endfunction

  function automatic void predict_digest(input logic [31:0] w, input logic [2:0] cnt,
                                         input logic eom);
    int n;
    logic [31:0] keep;
    digest_beat_t beat;
    if (!eom) begin
      msg_bits += 64'd32;
      push_sched_word(w);
    end else begin
      n = (cnt > 3'd4) ? 4 : int'(cnt);
      msg_bits += 64'(n * 8);
      if (n == 4) begin
        push_sched_word(w);
        push_sched_word({sha1md_pkg::PAD_BYTE, 24'h0});
      end else begin
        keep = (n == 0) ? 32'h0 : (~32'h0 << (32 - 8 * n));
        push_sched_word((w & keep) | ({24'h0, sha1md_pkg::PAD_BYTE} << (24 - 8 * n)));
      end
      if (fill_pos == 4'd15) begin
        while (fill_pos != 4'd0) push_sched_word(32'h0);
      end
      while (fill_pos < 4'd14) push_sched_word(32'h0);
      push_sched_word(msg_bits[63:32]);
      push_sched_word(msg_bits[31:0]);
      for (int j = 0; j < sha1md_pkg::DIGEST_WORDS; j++) begin
        beat.digest_word = chain_h[j];
        beat.word_index  = 3'(j);
        beat.last_word   = (j == sha1md_pkg::DIGEST_WORDS - 1);
        digest_q.push_back(beat);
      end
      clear_digest_state();
    end
  endfunction

  function automatic int draw_gap(input int side);
    if (stretch_left[side] == 0) begin
      stretch_left[side] = $urandom_range(8, 40);
      calm_stretch[side] = ($urandom_range(0, 2) == 0);
    end
    stretch_left[side]--;
    return calm_stretch[side] ? 0 : $urandom_range(0, 15);
  endfunction

  task automatic send_word(input logic [31:0] w, input logic [2:0] cnt, input logic eom);
    int gap;
    gap = draw_gap(SIDE_WORD);
    if (gap > 0) begin
      word_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    word_ch.valid          <= 1'b1;
    word_ch.message_word   <= w;
    word_ch.byte_count     <= cnt;
    word_ch.end_of_message <= eom;
    do @(posedge clk); while (!word_ch.ready);
    predict_digest(w, cnt, eom);
    items_sent++;
  endtask

  task automatic send_message(input int body_words, input logic [2:0] tail_count,
                              input bit ragged);
    logic [2:0] cnt;
    for (int i = 0; i < body_words; i++) begin
      cnt = (ragged && $urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
      send_word($urandom, cnt, 1'b0);
    end
    send_word($urandom, tail_count, 1'b1);
  endtask

  task automatic test_short_messages();
    send_word(32'hFFFF_FFFF, 3'd0, 1'b1);
    send_word(32'h6162_63FF, 3'd3, 1'b1);
    send_word(32'hFFFF_FFFF, 3'd4, 1'b1);
    send_word(32'h0000_0000, 3'd4, 1'b1);
  endtask

  task automatic test_final_byte_counts();
    send_word(32'hA5FF_FFFF, 3'd1, 1'b1);
    send_word(32'h3C5A_FFFF, 3'd2, 1'b1);
    send_word(32'h0123_4567, 3'd5, 1'b1);
    send_word(32'h89AB_CDEF, 3'd6, 1'b1);
    send_word(32'hFEDC_BA98, 3'd7, 1'b1);
  endtask

  task automatic test_ragged_body_counts();
    send_word(32'hDEAD_BEEF, 3'd0, 1'b0);
    send_word(32'h1234_5678, 3'd3, 1'b0);
    send_word(32'hCAFE_F00D, 3'd7, 1'b0);
    send_word(32'h5555_AAAA, 3'd2, 1'b1);
  endtask

  task automatic test_extra_block();
    send_message(13, 3'd4, 1'b0);
  endtask

  task automatic test_output_backpressure();
    hold_off_req = HOLD_OFF_CYCLES;
    repeat (8) send_message($urandom_range(0, 2), 3'($urandom_range(0, 4)), 1'b0);
  endtask

  task automatic test_random_messages();
    int pick;
    int body;
    logic [2:0] tail;
    while (items_sent < TARGET_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        body = $urandom_range(0, 4);
      end else if (pick < 7) begin
        body = $urandom_range(12, 17);
      end else if (pick < 9) begin
        body = $urandom_range(18, 40);
      end else begin
        body = $urandom_range(41, 64);
      end
      tail = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(5, 7))
                                         : 3'($urandom_range(0, 4));
      send_message(body, tail, $urandom_range(0, 7) == 0);
    end
  endtask

  initial begin : digest_sink
    int stall;
    digest_ch.ready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req > 0) begin
        stall = hold_off_req;
        hold_off_req = 0;
      end else begin
        stall = draw_gap(SIDE_DIGEST);
      end
      if (stall > 0) begin
        digest_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      digest_ch.ready <= 1'b1;
      do @(posedge clk); while (!digest_ch.valid);
    end
  end

  always @(posedge clk) begin : check_digest
    digest_beat_t want;
    if (rst_n && digest_ch.valid && digest_ch.ready) begin
      if (digest_q.size() == 0) begin
        $error("unexpected digest beat: digest_word %h word_index %0d last_word %0b",
               digest_ch.digest_word, digest_ch.word_index, digest_ch.last_word);
        fail_count++;
      end else begin
        want = digest_q.pop_front();
        if (digest_ch.digest_word !== want.digest_word) begin
          $error("digest_word: expected %h, got %h", want.digest_word, digest_ch.digest_word);
          fail_count++;
        end
        if (digest_ch.word_index !== want.word_index) begin
          $error("word_index: expected %0d, got %0d", want.word_index, digest_ch.word_index);
          fail_count++;
        end
        if (digest_ch.last_word !== want.last_word) begin
          $error("last_word: expected %0b, got %0b", want.last_word, digest_ch.last_word);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((word_ch.valid && word_ch.ready) || (digest_ch.valid && digest_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == STALL_LIMIT) begin
      $display("tb_sha1_message_digest failed");
      $finish;
    end
  end

  initial begin
    word_ch.valid          <= 1'b0;
    word_ch.message_word   <= '0;
    word_ch.byte_count     <= '0;
    word_ch.end_of_message <= 1'b0;
    clear_digest_state();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_short_messages();
    test_final_byte_counts();
    test_ragged_body_counts();
    test_extra_block();
    test_output_backpressure();
    test_random_messages();
    word_ch.valid <= 1'b0;

    while (digest_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && digest_q.size() == 0) begin
      $display("tb_sha1_message_digest passed");
    end else begin
      $display("tb_sha1_message_digest failed");
    end
    $finish;
  end

endmodule
